// ===== hw/rtl/timap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package timap_pkg;

	localparam logic [1:0] KIND_ADD     = 2'd0;
	localparam logic [1:0] KIND_LOOKUP  = 2'd1;
	localparam logic [1:0] KIND_REPLACE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_ORDER     = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	localparam logic signed [10:0] TGT_IGNORE = -11'sd1;

	// controller to datapath
	typedef struct packed {
		logic       start;
		logic       skip_all;
		logic       step;
		logic       track;
		logic       emit_entry;
		logic       emit_s;
		logic       emit_e;
		logic       finish_paint;
		logic       finish_empty;
		logic       set_st;
		logic [1:0] st;
		logic       out_load;
		logic       lookup;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] kind;
		logic       bad_order;
		logic       empty_span;
		logic       v_neg;
		logic       at_end;
		logic       lt_s;
		logic       le_e;
		logic       gt_q;
		logic       s_done;
		logic       e_done;
		logic       out_busy;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/timap_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module timap_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire timap_pkg::stat_t st,
	output timap_pkg::cmd_t     cmd
);
	import timap_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_RD_L   = 7'b0000100,
		S_CHK_L  = 7'b0001000,
		S_RD_P   = 7'b0010000,
		S_CHK_P  = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   lookup_q, lookup_d;

	assign in_stall = (state_q != S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lookup_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			lookup_q <= lookup_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		lookup_d = lookup_q;
		cmd      = '0;
		cmd.lookup = lookup_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				lookup_d = 1'b0;
				cmd.set_st = 1'b1;
				cmd.st     = ST_OK;
				state_d    = S_DONE;
				if (st.kind == KIND_LOOKUP) begin
					lookup_d = 1'b1;
					state_d  = S_RD_L;
				end else if (st.kind == KIND_ADD || st.kind == KIND_REPLACE) begin
					if (st.bad_order) begin
						cmd.st = ST_ORDER;
					end else if (st.kind == KIND_REPLACE) begin
						if (st.empty_span || st.v_neg) begin
							cmd.finish_empty = 1'b1;
						end else begin
							cmd.skip_all = 1'b1;
							state_d      = S_RD_P;
						end
					end else if (!st.empty_span) begin
						state_d = S_RD_P;
					end
				end
			end
			S_RD_L: state_d = S_CHK_L;
			S_CHK_L: begin
				if (st.at_end || st.gt_q) begin
					state_d = S_DONE;
				end else begin
					cmd.track = 1'b1;
					cmd.step  = 1'b1;
					state_d   = S_RD_L;
				end
			end
			S_RD_P: state_d = S_CHK_P;
			S_CHK_P: begin
				priority if (!st.at_end && st.lt_s) begin
					cmd.emit_entry = 1'b1;
					cmd.track      = 1'b1;
					cmd.step       = 1'b1;
					state_d        = S_RD_P;
				end else if (!st.at_end && st.le_e) begin
					cmd.track = 1'b1;
					cmd.step  = 1'b1;
					state_d   = S_RD_P;
				end else if (!st.s_done) begin
					cmd.emit_s = 1'b1;
				end else if (!st.e_done) begin
					cmd.emit_e = 1'b1;
				end else if (!st.at_end) begin
					cmd.emit_entry = 1'b1;
					cmd.step       = 1'b1;
					state_d        = S_RD_P;
				end else begin
					cmd.finish_paint = 1'b1;
					state_d          = S_DONE;
				end
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/timap_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module timap_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire timap_pkg::cmd_t    cmd,
	output timap_pkg::stat_t        st,
	input  wire logic [1:0]         kind,
	input  wire logic signed [63:0] start_time,
	input  wire logic signed [63:0] stop_time,
	input  wire logic signed [10:0] target_index,
	input  wire logic signed [63:0] query_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [10:0]      target_at_time,
	output logic [1:0]              status,
	output logic [6:0]              entries_used
);
	import timap_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// two banks, the live one chosen by sel_q
	logic [63:0] mem_time [2**(AW+1)];
	logic [10:0] mem_tgt  [2**(AW+1)];

	logic [1:0]         kind_q;
	logic signed [63:0] s_q, e_q, q_q;
	logic signed [10:0] v_q;
	logic [CW-1:0]      i_q, kept_q, count_q;
	logic signed [10:0] prev_q, track_q;
	logic               s_done_q, e_done_q, ovf_q, sel_q;
	logic [1:0]         st_q;
	logic signed [63:0] rd_time_q;
	logic signed [10:0] rd_tgt_q;
	logic               out_valid_q;
	logic signed [10:0] out_tgt_q;
	logic [1:0]         out_st_q;
	logic [6:0]         out_used_q;

	logic               emit;
	logic signed [63:0] emit_time;
	logic signed [10:0] emit_tgt;
	logic [31:0]        count_ext;

	// status to controller
	always_comb begin
		st.kind       = kind_q;
		st.bad_order  = (e_q < s_q);
		st.empty_span = (e_q == s_q);
		st.v_neg      = v_q[10];
		st.at_end     = (i_q == count_q);
		st.lt_s       = (rd_time_q < s_q);
		st.le_e       = !(e_q < rd_time_q);
		st.gt_q       = (q_q < rd_time_q);
		st.s_done     = s_done_q;
		st.e_done     = e_done_q;
		st.out_busy   = out_valid_q && out_stall;
	end

	// word emitted into the new bank
	always_comb begin
		emit      = cmd.emit_entry || cmd.emit_s || cmd.emit_e;
		emit_time = rd_time_q;
		emit_tgt  = rd_tgt_q;
		if (cmd.emit_s) begin
			emit_time = s_q;
			emit_tgt  = v_q;
		end else if (cmd.emit_e) begin
			emit_time = e_q;
			emit_tgt  = track_q;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		rd_time_q <= mem_time[{sel_q, i_q[AW-1:0]}];
		rd_tgt_q  <= mem_tgt[{sel_q, i_q[AW-1:0]}];
		if (emit && emit_tgt != prev_q && kept_q != DEPTH_C) begin
			mem_time[{~sel_q, kept_q[AW-1:0]}] <= emit_time;
			mem_tgt[{~sel_q, kept_q[AW-1:0]}]  <= emit_tgt;
		end
	end

	// item latch and walk registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q   <= kind;
			s_q      <= start_time;
			e_q      <= stop_time;
			q_q      <= query_time;
			v_q      <= target_index[10] ? TGT_IGNORE : target_index;
			i_q      <= '0;
			kept_q   <= '0;
			prev_q   <= TGT_IGNORE;
			track_q  <= TGT_IGNORE;
			s_done_q <= 1'b0;
			e_done_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (cmd.skip_all) i_q <= count_q;
			if (cmd.step)     i_q <= i_q + 1'b1;
			if (cmd.track)    track_q <= rd_tgt_q;
			if (cmd.emit_s)   s_done_q <= 1'b1;
			if (cmd.emit_e)   e_done_q <= 1'b1;
			if (emit) begin
				prev_q <= emit_tgt;
				if (emit_tgt != prev_q) begin
					if (kept_q == DEPTH_C) ovf_q <= 1'b1;
					else kept_q <= kept_q + 1'b1;
				end
			end
			if (cmd.set_st) st_q <= cmd.st;
			if (cmd.finish_paint) st_q <= ovf_q ? ST_OVERFLOW : ST_OK;
		end
	end

	// live bank and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sel_q   <= 1'b0;
		end else if (cmd.finish_empty) begin
			count_q <= '0;
		end else if (cmd.finish_paint && !ovf_q) begin
			count_q <= kept_q;
			sel_q   <= ~sel_q;
		end
	end

	assign count_ext = 32'(count_q);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_tgt_q  <= cmd.lookup ? track_q : TGT_IGNORE;
			out_st_q   <= st_q;
			out_used_q <= count_ext[6:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign target_at_time = out_tgt_q;
	assign status         = out_st_q;
	assign entries_used   = out_used_q;

endmodule
`default_nettype wire

// ===== hw/rtl/time_interval_target_map_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake            fields
// in       input      in_valid / in_stall  kind, start_time, stop_time, target_index, query_time
// out      output     out_valid/out_stall  target_at_time, status, entries_used
//
// one item at a time; a lookup or an add walks the stored breakpoints,
// reading one entry from the table memory and then checking it at each step
// an add or a replace rewrites the table into the spare bank, which becomes live unless it overflows
// reset clears the entry count and the sequencer; the table needs no clearing
// a stalled result holds in its register while the next word is taken in
module time_interval_target_map_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [63:0] start_time,
	input  wire logic signed [63:0] stop_time,
	input  wire logic signed [10:0] target_index,
	input  wire logic signed [63:0] query_time,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [10:0]      target_at_time,
	output logic [1:0]              status,
	output logic [6:0]              entries_used
);
	import timap_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencer
	timap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// table and result datapath
	timap_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.kind           (kind),
		.start_time     (start_time),
		.stop_time      (stop_time),
		.target_index   (target_index),
		.query_time     (query_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_at_time (target_at_time),
		.status         (status),
		.entries_used   (entries_used)
	);

endmodule
`default_nettype wire
